// ===== design/lpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_W        = 21;
  localparam int DIV_CNT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd6;

  localparam logic [11:0] LINE_THRESHOLD = 12'd100;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic mul1;
    logic mul2;
    logic div_step;
    logic sum;
    logic spd1;
    logic spd2;
  } lpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic do_upd;
  } lpd_stat_t;

  typedef struct packed {
    logic              hit;
    logic              use_sampled;
    logic signed [3:0] val;
  } lpd_dec_t;

  // ir pattern to position error
  function automatic lpd_dec_t lpd_decode(input logic [SENSOR_COUNT-1:0] bits);
    lpd_dec_t d;
    d.hit = 1'b1;
    d.use_sampled = 1'b0;
    d.val = 4'sd0;
    case (bits)
      8'h18, 8'hFF: d.val = 4'sd0;
      8'h10: d.val = 4'sd1;
      8'h30: d.val = 4'sd2;
      8'h20: d.val = 4'sd3;
      8'h60: d.val = 4'sd4;
      8'h40: d.val = 4'sd5;
      8'hC0: d.val = 4'sd6;
      8'h80, 8'hE0, 8'hF0, 8'hF8: d.val = 4'sd7;
      8'h08: d.val = -4'sd1;
      8'h0C: d.val = -4'sd2;
      8'h04: d.val = -4'sd3;
      8'h06: d.val = -4'sd4;
      8'h02: d.val = -4'sd5;
      8'h03: d.val = -4'sd6;
      8'h01, 8'h07, 8'h0F, 8'h1F: d.val = -4'sd7;
      8'h00: d.use_sampled = 1'b1;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/line_position_pid_motor_drive.sv =====
// Line follower steering block. Each item carries the 8-bit ir pattern, the
// center sensor level, a millisecond time stamp and a clear flag; it gives one
// result with left and right duty, reverse flags and the position error used.
// When the configured sample period has elapsed since the last update, the
// pid value is recomputed (q8.8 gains, saturating 24-bit integral, signed
// q32.8 control value); otherwise the previous control value steers.
// Without a pid update an item passes the accept, mul1, spd1 and spd2 states;
// with one it also passes mul2, the 21-step shift/subtract divider for the
// derivative term and sum. spd2 waits while an earlier result is still held,
// and the next item is taken only once the block is idle again. Config writes
// are always taken, but belong only where the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module line_position_pid_motor_drive
  import lpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // config write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SENSOR_COUNT-1:0] in_sensor_bits,
  input  wire logic [11:0]             in_line_level,
  input  wire logic [31:0]             in_now_ms,
  input  wire logic                    in_clear_state,
  // result items
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_right_duty,
  output logic                         out_right_reverse,
  output logic [7:0]                   out_left_duty,
  output logic                         out_left_reverse,
  output logic signed [3:0]            out_position_error
);

  lpd_cmd_t  cmd;
  lpd_stat_t stat;

  // config registers never stall
  assign cfg_ready = 1'b1;

  // sequencer: accept, pid multiplies, divide, sum, speed stages
  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // decode, pid arithmetic, speed clamps and output register
  lpd_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sensor_bits     (in_sensor_bits),
    .in_line_level      (in_line_level),
    .in_now_ms          (in_now_ms),
    .in_clear_state     (in_clear_state),
    .out_right_duty     (out_right_duty),
    .out_right_reverse  (out_right_reverse),
    .out_left_duty      (out_left_duty),
    .out_left_reverse   (out_left_reverse),
    .out_position_error (out_position_error)
  );

endmodule

`default_nettype wire

// ===== design/lpd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpd_ctrl
  import lpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire lpd_stat_t stat,
  output lpd_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_SPD1 = 3'd5;
  localparam logic [2:0] S_SPD2 = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (stat.do_upd) begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_SPD1;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SPD1;
      end
      S_SPD1: begin
        cmd.spd1  = 1'b1;
        state_nxt = S_SPD2;
      end
      S_SPD2: begin
        if (!ovalid_r || out_ready) begin
          cmd.spd2   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lpd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpd_datapath
  import lpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lpd_cmd_t                cmd,
  output lpd_stat_t                    stat,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [SENSOR_COUNT-1:0] in_sensor_bits,
  input  wire logic [11:0]             in_line_level,
  input  wire logic [31:0]             in_now_ms,
  input  wire logic                    in_clear_state,
  output logic [7:0]                   out_right_duty,
  output logic                         out_right_reverse,
  output logic [7:0]                   out_left_duty,
  output logic                         out_left_reverse,
  output logic signed [3:0]            out_position_error
);

  // configuration
  logic [15:0]       kp_r, ki_r, kd_r, per_r;
  logic signed [8:0] base_r, min_r, max_r;
  logic [15:0]       per_eff;

  // control state
  logic signed [3:0]  cur_r, samp_r;
  logic signed [23:0] integ_r;
  logic signed [39:0] cv_r;
  logic [31:0]        last_r;

  // per item work registers
  logic [31:0]        now_r;
  logic               upd_r;
  logic [31:0]        kit_r;
  logic signed [21:0] kdd_r;
  logic signed [20:0] pterm_r;
  logic signed [56:0] iterm_r;
  logic               dneg_r;
  logic [DIV_W-1:0]   qd_r;
  logic [15:0]        rem_r;
  logic signed [40:0] lsp_r, rsp_r;

  logic [7:0]        rduty_r, lduty_r;
  logic              rrev_r, lrev_r;
  logic signed [3:0] perr_r;

  lpd_dec_t           dec;
  logic signed [3:0]  e_nxt;
  logic [31:0]        elapsed;
  logic signed [4:0]  dlt;
  logic signed [21:0] kdd;
  logic signed [20:0] pterm;
  logic signed [24:0] isum;
  logic signed [23:0] isat;
  logic [16:0]        rem_sh;
  logic               ge;
  logic signed [21:0] dterm;
  logic signed [57:0] acc;
  logic signed [39:0] acc_sat;
  logic signed [40:0] base_sc;
  logic [21:0]        kdd_mag;

  assign per_eff = (per_r == 16'd0) ? 16'd1 : per_r;
  assign stat.do_upd = upd_r;

  always_comb begin
    dec   = lpd_decode(in_sensor_bits);
    e_nxt = cur_r;
    if (dec.hit) e_nxt = dec.use_sampled ? samp_r : dec.val;
    if (in_line_level > LINE_THRESHOLD) e_nxt = 4'sd0;
  end

  assign elapsed = in_now_ms - last_r;

  assign dlt   = {cur_r[3], cur_r} - {samp_r[3], samp_r};
  assign kdd   = $signed({1'b0, kd_r}) * dlt;
  assign pterm = $signed({1'b0, kp_r}) * cur_r;
  assign isum  = {integ_r[23], integ_r} + {{21{cur_r[3]}}, cur_r};
  always_comb begin
    if (isum[24] != isum[23]) isat = isum[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    else isat = isum[23:0];
  end

  assign kdd_mag = kdd_r[21] ? -kdd_r : kdd_r;

  // restoring division step
  assign rem_sh = {rem_r, qd_r[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, per_eff});

  assign dterm = dneg_r ? -$signed({1'b0, qd_r}) : $signed({1'b0, qd_r});
  assign acc   = {iterm_r[56], iterm_r} + {{37{pterm_r[20]}}, pterm_r}
               + {{36{dterm[21]}}, dterm};
  always_comb begin
    if (acc[57:39] == {19{acc[39]}}) acc_sat = acc[39:0];
    else acc_sat = acc[57] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  end

  assign base_sc = {{24{base_r[8]}}, base_r, 8'd0};

  // trunc toward zero by 256, clamp to max then min
  function automatic logic signed [8:0] spd_of(input logic signed [40:0] x,
                                               input logic signed [8:0] mx,
                                               input logic signed [8:0] mn);
    logic signed [40:0] t;
    logic signed [32:0] s;
    t = x[40] ? x + 41'sd255 : x;
    s = t[40:8];
    if (s > $signed({{24{mx[8]}}, mx})) s = $signed({{24{mx[8]}}, mx});
    if (s < $signed({{24{mn[8]}}, mn})) s = $signed({{24{mn[8]}}, mn});
    return s[8:0];
  endfunction

  function automatic logic [7:0] duty_of(input logic signed [8:0] s);
    logic [8:0] m;
    m = s[8] ? 9'(-s) : s;
    return m[8] ? 8'hFF : m[7:0];
  endfunction

  logic signed [8:0] ls, rs;
  assign ls = spd_of(lsp_r, max_r, min_r);
  assign rs = spd_of(rsp_r, max_r, min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= 16'd12800;
      ki_r    <= 16'd0;
      kd_r    <= 16'd0;
      per_r   <= 16'd1;
      base_r  <= 9'sd170;
      min_r   <= -9'sd100;
      max_r   <= 9'sd200;
      cur_r   <= '0;
      samp_r  <= '0;
      integ_r <= '0;
      cv_r    <= '0;
      last_r  <= '0;
      upd_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP:   kp_r   <= cfg_data;
          REG_INTEG:  ki_r   <= cfg_data;
          REG_DERIV:  kd_r   <= cfg_data;
          REG_PERIOD: per_r  <= cfg_data;
          REG_BASE:   base_r <= cfg_data[8:0];
          REG_MIN:    min_r  <= cfg_data[8:0];
          REG_MAX:    max_r  <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (cmd.cap) begin
        cur_r <= e_nxt;
        upd_r <= (elapsed >= {16'd0, per_eff});
        if (in_clear_state) integ_r <= '0;
      end
      if (cmd.mul1) begin
        integ_r <= isat;
        samp_r  <= cur_r;
        last_r  <= now_r;
      end
      if (cmd.sum) cv_r <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) now_r <= in_now_ms;
    if (cmd.mul1) begin
      kit_r   <= ki_r * per_eff;
      kdd_r   <= kdd;
      pterm_r <= pterm;
    end
    if (cmd.mul2) begin
      iterm_r <= $signed({1'b0, kit_r}) * integ_r;
      dneg_r  <= kdd_r[21];
      qd_r    <= kdd_mag[DIV_W-1:0];
      rem_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 16'(rem_sh - {1'b0, per_eff}) : rem_sh[15:0];
      qd_r  <= {qd_r[DIV_W-2:0], ge};
    end
    if (cmd.spd1) begin
      lsp_r <= base_sc - {cv_r[39], cv_r};
      rsp_r <= base_sc + {cv_r[39], cv_r};
    end
    if (cmd.spd2) begin
      rduty_r <= duty_of(rs);
      rrev_r  <= rs[8] | (rs == 9'sd0);
      lduty_r <= duty_of(ls);
      lrev_r  <= ls[8] | (ls == 9'sd0);
      perr_r  <= cur_r;
    end
  end

  assign out_right_duty     = rduty_r;
  assign out_right_reverse  = rrev_r;
  assign out_left_duty      = lduty_r;
  assign out_left_reverse   = lrev_r;
  assign out_position_error = perr_r;

endmodule

`default_nettype wire
